// File: sv/lfra_pkg.sv
// Shared types and constants for the lowest-free-room allocator.
// Used by lfra_ctrl, lfra_dpath and lowest_free_room_allocator; no dependencies.
package lfra_pkg;

  localparam int PADDR_W = 3;

  // Register index taken from paddr[2] (one 32-bit register at byte 0).
  localparam logic REG_ROOMS_IN_USE = 1'b0;

  localparam logic [4:0]  ROOMS_RESET   = 5'd16;
  localparam logic [47:0] FREE_TIME_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] USE_COUNT_MAX = 32'hFFFF_FFFF;

  // Scan kinds.
  localparam logic SCAN_ALLOC = 1'b0;
  localparam logic SCAN_COUNT = 1'b1;

  typedef struct packed {
    logic [31:0] use_count;
    logic [47:0] free_time;
  } room_entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // capture the request fields
    logic clear_scan;  // rewind the scan address, reset trackers
    logic scan_mode;   // SCAN_ALLOC or SCAN_COUNT, taken with clear_scan
    logic issue_read;  // read the room at the scan address, advance
    logic write_back;  // write the chosen room, latch the result
    logic clear_rooms; // drop every room entry back to zero
    logic load_out;    // move the result into the output register
  } lfra_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last;   // scan address is the last active room
    logic item_last;   // captured request carries the last-meeting mark
    logic out_free;    // output register can take a result this cycle
  } lfra_stat_t;

endpackage

// File: sv/lfra_ctrl.sv
// Sequencing state machine of the lowest-free-room allocator.
// Depends on lfra_pkg; drives lfra_dpath through lfra_cmd_t.
module lfra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lfra_pkg::lfra_stat_t stat,
  output lfra_pkg::lfra_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_CSCAN,
    ST_CDRAIN,
    ST_CLEAR,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load       = 1'b1;
          cmd.clear_scan = 1'b1;
          cmd.scan_mode  = lfra_pkg::SCAN_ALLOC;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue_read = 1'b1;
        if (stat.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.write_back = 1'b1;
        if (stat.item_last) begin
          cmd.clear_scan = 1'b1;
          cmd.scan_mode  = lfra_pkg::SCAN_COUNT;
          state_next     = ST_CSCAN;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_CSCAN: begin
        cmd.issue_read = 1'b1;
        if (stat.scan_last) state_next = ST_CDRAIN;
      end
      ST_CDRAIN: begin
        state_next = ST_CLEAR;
      end
      ST_CLEAR: begin
        cmd.clear_rooms = 1'b1;
        state_next      = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/lfra_dpath.sv
// Datapath of the lowest-free-room allocator: room memory, scan trackers,
// write-back arithmetic and the output register. Depends on lfra_pkg.
module lfra_dpath #(
  parameter int MAX_ROOMS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lfra_pkg::lfra_cmd_t  cmd,
  output lfra_pkg::lfra_stat_t stat,
  input  logic [4:0]           rooms_in_use,
  input  logic [31:0]          start_time,
  input  logic [31:0]          end_time,
  input  logic                 last_meeting,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [3:0]           assigned_room,
  output logic                 was_delayed,
  output logic [3:0]           most_booked_room,
  output logic                 answer_valid
);

  localparam int RW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;

  // Room storage; valid bits stand in for the zero reset value.
  lfra_pkg::room_entry_t room_mem [MAX_ROOMS];
  logic [MAX_ROOMS-1:0]  room_valid;

  // Captured request.
  logic [31:0] item_start;
  logic [31:0] item_end;
  logic [31:0] item_dur;
  logic        item_last;

  // Scan address and read stage.
  logic [RW-1:0]         addr;
  logic                  scan_mode;
  logic                  rd_vld;
  logic                  rd_mode;
  logic [RW-1:0]         rd_idx;
  logic                  rd_ok;
  lfra_pkg::room_entry_t rd_entry;
  logic [47:0]           rd_free;
  logic [31:0]           rd_cnt;

  // Trackers.
  logic          found;
  logic [RW-1:0] found_idx;
  logic [31:0]   found_cnt;
  logic [RW-1:0] min_idx;
  logic [47:0]   min_free;
  logic [31:0]   min_cnt;
  logic [RW-1:0] best_idx;
  logic [31:0]   best_cnt;

  // Result latched at write-back.
  logic [RW-1:0] res_room;
  logic          res_delayed;

  // Write-back arithmetic.
  logic [RW-1:0]         chosen;
  logic [31:0]           base_cnt;
  logic [48:0]           delay_sum;
  lfra_pkg::room_entry_t wr_entry;

  // Last active room index.
  logic [6:0]    rin_ext;
  logic [6:0]    lim;
  logic [RW-1:0] last_idx;

  always_comb begin
    rin_ext = 7'(rooms_in_use);
    if (rin_ext == 7'd0) begin
      lim = 7'd0;
    end else if (rin_ext > 7'(MAX_ROOMS)) begin
      lim = 7'(MAX_ROOMS - 1);
    end else begin
      lim = rin_ext - 7'd1;
    end
    last_idx = lim[RW-1:0];
  end

  assign stat.scan_last = (addr == last_idx);
  assign stat.item_last = item_last;
  assign stat.out_free  = !out_valid || !out_stall;

  assign rd_free = rd_ok ? rd_entry.free_time : 48'd0;
  assign rd_cnt  = rd_ok ? rd_entry.use_count : 32'd0;

  always_comb begin
    chosen    = found ? found_idx : min_idx;
    base_cnt  = found ? found_cnt : min_cnt;
    delay_sum = {1'b0, min_free} + 49'(item_dur);
    wr_entry.use_count = (base_cnt == lfra_pkg::USE_COUNT_MAX) ? base_cnt
                                                               : base_cnt + 32'd1;
    if (found) begin
      wr_entry.free_time = 48'(item_end);
    end else if (delay_sum[48]) begin
      wr_entry.free_time = lfra_pkg::FREE_TIME_MAX;
    end else begin
      wr_entry.free_time = delay_sum[47:0];
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.write_back) begin
      room_mem[chosen] <= wr_entry;
    end
    if (cmd.issue_read) begin
      rd_entry <= room_mem[addr];
    end
  end

  // Control state: valid bits, scan pointer, trackers, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      room_valid <= '0;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
      found      <= 1'b0;
      addr       <= '0;
      scan_mode  <= lfra_pkg::SCAN_ALLOC;
    end else begin
      rd_vld <= cmd.issue_read;
      if (cmd.clear_rooms) begin
        room_valid <= '0;
      end else if (cmd.write_back) begin
        room_valid[chosen] <= 1'b1;
      end
      if (cmd.clear_scan) begin
        addr      <= '0;
        scan_mode <= cmd.scan_mode;
        if (cmd.scan_mode == lfra_pkg::SCAN_ALLOC) found <= 1'b0;
      end else if (cmd.issue_read) begin
        addr <= addr + RW'(1);
      end
      if (rd_vld && rd_mode == lfra_pkg::SCAN_ALLOC && !found
          && rd_free <= 48'(item_start)) begin
        found <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_start <= start_time;
      item_end   <= end_time;
      item_dur   <= (end_time >= start_time) ? end_time - start_time : 32'd0;
      item_last  <= last_meeting;
    end
    if (cmd.issue_read) begin
      rd_ok   <= room_valid[addr];
      rd_idx  <= addr;
      rd_mode <= scan_mode;
    end
    if (rd_vld) begin
      if (rd_mode == lfra_pkg::SCAN_ALLOC) begin
        if (!found && rd_free <= 48'(item_start)) begin
          found_idx <= rd_idx;
          found_cnt <= rd_cnt;
        end
        // Strict less-than keeps the lowest index on ties.
        if (rd_idx == '0 || rd_free < min_free) begin
          min_idx  <= rd_idx;
          min_free <= rd_free;
          min_cnt  <= rd_cnt;
        end
      end else begin
        if (rd_idx == '0 || rd_cnt > best_cnt) begin
          best_idx <= rd_idx;
          best_cnt <= rd_cnt;
        end
      end
    end
    if (cmd.write_back) begin
      res_room    <= chosen;
      res_delayed <= !found;
    end
    if (cmd.load_out) begin
      assigned_room    <= 4'(res_room);
      was_delayed      <= res_delayed;
      most_booked_room <= item_last ? 4'(best_idx) : 4'd0;
      answer_valid     <= item_last;
    end
  end

endmodule

// File: sv/lowest_free_room_allocator.sv
// Top level of the lowest-free-room allocator: APB register, controller
// and datapath. Depends on lfra_pkg, lfra_ctrl and lfra_dpath.
//
// Books meetings, given in ascending start order, onto up to MAX_ROOMS rooms.
// Each request goes to the lowest-numbered room free at its start; if none is
// free it is delayed onto the room that frees earliest (lowest index on ties)
// and keeps its duration. Every request yields one result with the room and a
// delay flag. A request marked last also reports the most-used room (lowest
// index on ties) with answer_valid set, and then clears all room state.
// Scan: with n active rooms (rooms_in_use clamped to 1..MAX_ROOMS) a request
// is scanned over rooms 0 to n-1 and then written back; a last request is
// followed by a second pass over the use counts and a clear. The scan pace is
// set by the single read port of the room memory, which it walks one room per
// cycle. in_stall stays high while a request is being worked; a finished
// result waits in the output register while the next request is scanned.
// The memory is cleared by dropping its per-room valid bits, so no clearing
// pass follows reset. Write rooms_in_use (register 0, byte address 0) only
// while the block is idle.
module lowest_free_room_allocator #(
  parameter int MAX_ROOMS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // APB register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfra_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [31:0]                  start_time,
  input  logic [31:0]                  end_time,
  input  logic                         last_meeting,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [3:0]                   assigned_room,
  output logic                         was_delayed,
  output logic [3:0]                   most_booked_room,
  output logic                         answer_valid
);

  logic [4:0]           rooms_in_use;
  logic                 reg_sel;
  lfra_pkg::lfra_cmd_t  cmd;
  lfra_pkg::lfra_stat_t stat;

  // Register index sits above the byte offset.
  assign reg_sel = (paddr[2] == lfra_pkg::REG_ROOMS_IN_USE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? 32'(rooms_in_use) : 32'd0;

  // Hold the room count; a write takes effect from the next request.
  always_ff @(posedge clk) begin
    if (rst) begin
      rooms_in_use <= lfra_pkg::ROOMS_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      rooms_in_use <= pwdata[4:0];
    end
  end

  lfra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfra_dpath #(
    .MAX_ROOMS (MAX_ROOMS)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .rooms_in_use     (rooms_in_use),
    .start_time       (start_time),
    .end_time         (end_time),
    .last_meeting     (last_meeting),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .assigned_room    (assigned_room),
    .was_delayed      (was_delayed),
    .most_booked_room (most_booked_room),
    .answer_valid     (answer_valid)
  );

endmodule
